FILE: rtl/hkrs_pkg.sv
package hkrs_pkg;

  // Event codes carried with each input word
  typedef enum logic [3:0] {
    OP_CONNECT      = 4'd0,
    OP_FRAME_TICK   = 4'd1,
    OP_POLL         = 4'd2,
    OP_LED_REPORT   = 4'd3,
    OP_SET_IDLE     = 4'd4,
    OP_GET_IDLE     = 4'd5,
    OP_SET_PROTOCOL = 4'd6,
    OP_GET_PROTOCOL = 4'd7,
    OP_GET_REPORT   = 4'd8
  } hkrs_op_t;

  localparam int unsigned IdleW   = 11;
  localparam int unsigned ReportW = 40;

  localparam logic [IdleW-1:0] IdleResetMs = 11'd500;
  localparam logic [7:0]       ShiftMod    = 8'h02;
  localparam logic [7:0]       ScFirst     = 8'h04;
  localparam logic [3:0]       LedBase     = 4'h2;

  typedef logic [ReportW-1:0] hkrs_report_t;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [4:0]  key_states;
    logic        device_configured;
    logic        endpoint_ready;
    logic [15:0] request_value;
    logic [7:0]  led_byte;
  } hkrs_item_t;

  typedef struct packed {
    logic        report_sent;
    logic [7:0]  modifier_byte;
    logic [31:0] keycode_slots;
    logic        reply_valid;
    logic [7:0]  reply_byte;
    logic        led_valid;
    logic [3:0]  led_drive;
  } hkrs_result_t;

endpackage

FILE: rtl/hid_keyboard_report_scheduler.sv
// A word moves from the input register to the result register.
// Throughput: one word per cycle unless the output stalls; the input
// register refills in the cycle its word moves into the result register.
// Reset (rst_n low, synchronous): both stages empty, idle period 500 ms,
// idle counter zero, report protocol selected, last sent report zero.
module hid_keyboard_report_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [4:0] key_states, [5] device_configured, [6] endpoint_ready,
  // [22:7] request_value, [30:23] led_byte, [31] zero
  input  logic [31:0] in_tdata,
  // [3:0] opcode
  input  logic [3:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] modifier_byte, [39:8] keycode_slots, [47:40] reply_byte,
  // [51:48] led_drive, [55:52] zero
  output logic [55:0] out_tdata,
  // [0] report_sent, [1] reply_valid, [2] led_valid
  output logic [2:0]  out_tuser
);
  import hkrs_pkg::*;

  logic         in_valid_r;
  hkrs_item_t   item_r;
  logic         out_valid_r;
  hkrs_result_t res_r;
  hkrs_result_t res_nxt;
  logic         advance;
  logic         in_take;

  // Move the held word into the result register whenever that register is
  // empty or being drained this cycle; the state update goes with it.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_take   = in_tvalid && in_tready;

  hkrs_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (advance),
    .item   (item_r),
    .result (res_nxt)
  );

  // Input register: hold the word until the engine consumes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.opcode            <= in_tuser;
      item_r.key_states        <= in_tdata[4:0];
      item_r.device_configured <= in_tdata[5];
      item_r.endpoint_ready    <= in_tdata[6];
      item_r.request_value     <= in_tdata[22:7];
      item_r.led_byte          <= in_tdata[30:23];
    end
  end

  // Result register: hold until the downstream side takes the word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, res_r.led_drive, res_r.reply_byte,
                       res_r.keycode_slots, res_r.modifier_byte};
  assign out_tuser  = {res_r.led_valid, res_r.reply_valid, res_r.report_sent};

endmodule

FILE: rtl/hkrs_report_build.sv
module hkrs_report_build (
  input  logic [4:0]            key_states,
  output hkrs_pkg::hkrs_report_t report
);
  import hkrs_pkg::*;

  logic [1:0] slot;

  // Pack pressed keys A..D into consecutive slots above the modifier byte
  always_comb begin
    report = '0;
    slot   = '0;
    if (key_states[0]) begin
      report[7:0] = ShiftMod;
    end
    for (int k = 0; k < 4; k++) begin
      if (key_states[k+1]) begin
        report[8 + 8*slot +: 8] = ScFirst + 8'(k);
        slot = slot + 2'd1;
      end
    end
  end

endmodule

FILE: rtl/hkrs_engine.sv
module hkrs_engine (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  hkrs_pkg::hkrs_item_t  item,
  output hkrs_pkg::hkrs_result_t result
);
  import hkrs_pkg::*;

  logic [IdleW-1:0] idle_period_r, idle_period_nxt;
  logic [IdleW-1:0] idle_left_r, idle_left_nxt;
  logic             proto_r, proto_nxt;
  hkrs_report_t     last_sent_r, last_sent_nxt;
  hkrs_report_t     now_report;
  logic             want;

  hkrs_report_build u_build (
    .key_states (item.key_states),
    .report     (now_report)
  );

  always_comb begin
    idle_period_nxt = idle_period_r;
    idle_left_nxt   = idle_left_r;
    proto_nxt       = proto_r;
    last_sent_nxt   = last_sent_r;
    want            = 1'b0;
    result          = '0;
    case (hkrs_op_t'(item.opcode))
      OP_CONNECT: begin
        proto_nxt = 1'b1;
      end
      OP_FRAME_TICK: begin
        if (idle_left_r != '0) begin
          idle_left_nxt = idle_left_r - 1'b1;
        end
      end
      OP_POLL: begin
        if (item.device_configured) begin
          // Idle expiry reloads the counter even when the endpoint is busy
          if (idle_period_r != '0 && idle_left_r == '0) begin
            idle_left_nxt = idle_period_r;
            want          = 1'b1;
          end else begin
            want = (now_report != last_sent_r);
          end
          if (item.endpoint_ready && want) begin
            last_sent_nxt        = now_report;
            result.report_sent   = 1'b1;
            result.modifier_byte = now_report[7:0];
            result.keycode_slots = now_report[39:8];
          end
        end
      end
      OP_LED_REPORT: begin
        result.led_valid = 1'b1;
        result.led_drive = LedBase | {item.led_byte[2], item.led_byte[1], 1'b0,
                                      item.led_byte[0]};
      end
      OP_SET_IDLE: begin
        idle_period_nxt = {1'b0, item.request_value[15:8], 2'b00};
      end
      OP_GET_IDLE: begin
        result.reply_valid = 1'b1;
        result.reply_byte  = idle_period_r[9:2];
      end
      OP_SET_PROTOCOL: begin
        proto_nxt = (item.request_value != '0);
      end
      OP_GET_PROTOCOL: begin
        result.reply_valid = 1'b1;
        result.reply_byte  = {7'd0, proto_r};
      end
      OP_GET_REPORT: begin
        result.report_sent   = 1'b1;
        result.modifier_byte = now_report[7:0];
        result.keycode_slots = now_report[39:8];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_period_r <= IdleResetMs;
      idle_left_r   <= '0;
      proto_r       <= 1'b1;
      last_sent_r   <= '0;
    end else if (fire) begin
      idle_period_r <= idle_period_nxt;
      idle_left_r   <= idle_left_nxt;
      proto_r       <= proto_nxt;
      last_sent_r   <= last_sent_nxt;
    end
  end

endmodule
